[hw/rtl/ggl_pkg.sv]
package ggl_pkg;

  // fixed field widths of the register map and the channels
  localparam int CFG_DIM_W   = 9;
  localparam int CFG_STEP_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int COORD_W     = 8;
  localparam int IN_SAMPLE_W = 16;
  localparam int OUT_W       = 32;

  // register reset values
  localparam logic [CFG_DIM_W-1:0]  DIM_RST  = 9'd256;
  localparam logic [CFG_STEP_W-1:0] STEP_RST = 16'd256;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } ggl_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_HEIGHT   = 3'd1,
    REG_INV_STEP_X    = 3'd2,
    REG_INV_STEP_Y    = 3'd3,
    REG_INV_STEP_X_SQ = 3'd4,
    REG_INV_STEP_Y_SQ = 3'd5
  } ggl_reg_e;

  // where the queried point sits on one axis
  typedef struct packed {
    logic at_lo;
    logic at_hi;
  } ggl_pos_t;

  // reciprocal spacings, unsigned Q8.8
  typedef struct packed {
    logic [CFG_STEP_W-1:0] inv_x;
    logic [CFG_STEP_W-1:0] inv_y;
    logic [CFG_STEP_W-1:0] inv_x_sq;
    logic [CFG_STEP_W-1:0] inv_y_sq;
  } ggl_scale_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] gradient_x;
    logic signed [OUT_W-1:0] gradient_y;
    logic signed [OUT_W-1:0] laplacian_value;
  } ggl_result_t;

endpackage

[hw/rtl/ggl_if.sv]
// input channel: sample writes and derivative queries
interface ggl_in_if import ggl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic        [COORD_W-1:0]     x_coord;
  logic        [COORD_W-1:0]     y_coord;
  logic signed [IN_SAMPLE_W-1:0] sample_value;

  modport source (
    output valid, operation, x_coord, y_coord, sample_value,
    input  ready
  );
  modport sink (
    input  valid, operation, x_coord, y_coord, sample_value,
    output ready
  );
endinterface

// output channel: derivative results
interface ggl_out_if import ggl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] gradient_x;
  logic signed [OUT_W-1:0] gradient_y;
  logic signed [OUT_W-1:0] laplacian_value;

  modport source (
    output valid, gradient_x, gradient_y, laplacian_value,
    input  ready
  );
  modport sink (
    input  valid, gradient_x, gradient_y, laplacian_value,
    output ready
  );
endinterface

[hw/rtl/ggl_mem.sv]
// sample store: one write port, two read ports, registered read data
module ggl_mem #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hw/rtl/ggl_calc.sv]
// derivative datapath: differences and products, then shift, sum and saturate
module ggl_calc import ggl_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  ggl_pos_t                      pos_x_i,
  input  ggl_pos_t                      pos_y_i,
  input  logic signed [SAMPLE_BITS-1:0] xs_i [3],
  input  logic signed [SAMPLE_BITS-1:0] ys_i [3],
  input  ggl_scale_t                    scale_i,
  output logic                          done_o,
  output ggl_result_t                   res_o
);

  localparam int DG_W  = SAMPLE_BITS + 1;
  localparam int D2_W  = SAMPLE_BITS + 2;
  localparam int PG_W  = DG_W + CFG_STEP_W + 1;
  localparam int PL_W  = D2_W + CFG_STEP_W + 1;
  localparam int SAT_W = (PL_W + 1 > OUT_W + 2) ? PL_W + 1 : OUT_W + 2;

  logic                   v1_q, v2_q;
  logic signed [PG_W-1:0] prod_gx_q, prod_gy_q;
  logic signed [PL_W-1:0] prod_lx_q, prod_ly_q;
  logic                   half_x_q, half_y_q;
  ggl_result_t            res_q;

  logic signed [DG_W-1:0]  diff_x, diff_y;
  logic signed [D2_W-1:0]  d2_x, d2_y;
  logic signed [SAT_W-1:0] gx_w, gy_w, lap_w;

  // one-sided difference at an edge, central difference inside
  function automatic logic signed [DG_W-1:0] first_diff(
    input ggl_pos_t                      pos,
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b,
    input logic signed [SAMPLE_BITS-1:0] c
  );
    logic signed [DG_W-1:0] ea, eb, ec;
    ea = DG_W'(a);
    eb = DG_W'(b);
    ec = DG_W'(c);
    if (pos.at_lo) return eb - ea;
    if (pos.at_hi) return ec - eb;
    return ec - ea;
  endfunction

  // [1,-2,1] over the three window samples
  function automatic logic signed [D2_W-1:0] second_diff(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b,
    input logic signed [SAMPLE_BITS-1:0] c
  );
    return D2_W'(a) + D2_W'(c) - (D2_W'(b) <<< 1);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    if ((&v[SAT_W-1:OUT_W-1]) || !(|v[SAT_W-1:OUT_W-1])) begin
      return v[OUT_W-1:0];
    end
    return v[SAT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  always_comb begin
    diff_x = first_diff(pos_x_i, xs_i[0], xs_i[1], xs_i[2]);
    diff_y = first_diff(pos_y_i, ys_i[0], ys_i[1], ys_i[2]);
    d2_x   = second_diff(xs_i[0], xs_i[1], xs_i[2]);
    d2_y   = second_diff(ys_i[0], ys_i[1], ys_i[2]);
  end

  // stage 1: the four products
  always_ff @(posedge clk_i) begin
    prod_gx_q <= PG_W'(diff_x) * PG_W'(signed'({1'b0, scale_i.inv_x}));
    prod_gy_q <= PG_W'(diff_y) * PG_W'(signed'({1'b0, scale_i.inv_y}));
    prod_lx_q <= PL_W'(d2_x) * PL_W'(signed'({1'b0, scale_i.inv_x_sq}));
    prod_ly_q <= PL_W'(d2_y) * PL_W'(signed'({1'b0, scale_i.inv_y_sq}));
    half_x_q  <= !(pos_x_i.at_lo || pos_x_i.at_hi);
    half_y_q  <= !(pos_y_i.at_lo || pos_y_i.at_hi);
  end

  // stage 2: floor shifts (central difference also halves), sum, clamp
  always_comb begin
    gx_w  = half_x_q ? SAT_W'(prod_gx_q >>> 9) : SAT_W'(prod_gx_q >>> 8);
    gy_w  = half_y_q ? SAT_W'(prod_gy_q >>> 9) : SAT_W'(prod_gy_q >>> 8);
    lap_w = SAT_W'(prod_lx_q >>> 8) + SAT_W'(prod_ly_q >>> 8);
  end

  always_ff @(posedge clk_i) begin
    res_q.gradient_x      <= sat_out(gx_w);
    res_q.gradient_y      <= sat_out(gy_w);
    res_q.laplacian_value <= sat_out(lap_w);
  end

  // valid tracks the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  assign done_o = v2_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/grid_gradient_laplacian.sv]
// Write transaction: a new one can follow every cycle while no query is in progress.
// Query transaction: the result is registered and held until taken; no new item is
// taken until the sequence has run: three dual-port reads of the sample store (one
// x-axis and one y-axis neighbor each), a drain state and the two-stage datapath.
// Reset: control and config registers return to defaults; the sample store is
// not cleared and holds undefined data until written.
module grid_gradient_laplacian import ggl_pkg::*; #(
  parameter int MAX_DIM     = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ggl_in_if.sink                in_i,
  ggl_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int DW     = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [1:0] LAST_TAP = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_CALC,
    S_DONE
  } state_e;

  // configuration registers
  logic [CFG_DIM_W-1:0] grid_width_q, grid_height_q;
  ggl_scale_t           scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q     <= DIM_RST;
      grid_height_q    <= DIM_RST;
      scale_q.inv_x    <= STEP_RST;
      scale_q.inv_y    <= STEP_RST;
      scale_q.inv_x_sq <= STEP_RST;
      scale_q.inv_y_sq <= STEP_RST;
    end else if (cfg_we_i) begin
      case (ggl_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:    grid_width_q     <= cfg_data_i[CFG_DIM_W-1:0];
        REG_GRID_HEIGHT:   grid_height_q    <= cfg_data_i[CFG_DIM_W-1:0];
        REG_INV_STEP_X:    scale_q.inv_x    <= cfg_data_i;
        REG_INV_STEP_Y:    scale_q.inv_y    <= cfg_data_i;
        REG_INV_STEP_X_SQ: scale_q.inv_x_sq <= cfg_data_i;
        REG_INV_STEP_Y_SQ: scale_q.inv_y_sq <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_DIM_W-1:0] r);
    logic [DW-1:0] v;
    v = DW'(r);
    if (v < DW'(3)) return DW'(3);
    if (v > DW'(MAX_DIM)) return DW'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(
    input logic [COORD_W-1:0] col,
    input logic [COORD_W-1:0] row
  );
    return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
  endfunction

  // grid size in use and clamped query coordinates
  logic [DW-1:0]      w_eff, h_eff, w_m1, h_m1;
  logic [DW-1:0]      x_ext, y_ext;
  logic               in_grid;
  logic [COORD_W-1:0] qx_c, qy_c, sx_c, sy_c;
  ggl_pos_t           pos_x_c, pos_y_c;

  always_comb begin
    w_eff   = eff_dim(grid_width_q);
    h_eff   = eff_dim(grid_height_q);
    w_m1    = w_eff - DW'(1);
    h_m1    = h_eff - DW'(1);
    x_ext   = DW'(in_i.x_coord);
    y_ext   = DW'(in_i.y_coord);
    in_grid = (x_ext < w_eff) && (y_ext < h_eff);
    qx_c    = (x_ext >= w_eff) ? w_m1[COORD_W-1:0] : in_i.x_coord;
    qy_c    = (y_ext >= h_eff) ? h_m1[COORD_W-1:0] : in_i.y_coord;
    pos_x_c.at_lo = (qx_c == '0);
    pos_x_c.at_hi = (DW'(qx_c) == w_m1);
    pos_y_c.at_lo = (qy_c == '0);
    pos_y_c.at_hi = (DW'(qy_c) == h_m1);
    // three-point window start, pushed inward at an edge
    if (pos_x_c.at_lo)      sx_c = '0;
    else if (pos_x_c.at_hi) sx_c = qx_c - COORD_W'(2);
    else                    sx_c = qx_c - COORD_W'(1);
    if (pos_y_c.at_lo)      sy_c = '0;
    else if (pos_y_c.at_hi) sy_c = qy_c - COORD_W'(2);
    else                    sy_c = qy_c - COORD_W'(1);
  end

  // control
  state_e             state_q;
  logic [1:0]         cnt_q;
  logic               rd_pend_q;
  logic               start_q;
  logic               out_valid_q;
  ggl_result_t        out_data_q;
  logic [COORD_W-1:0] qx_q, qy_q, sx_q, sy_q;
  ggl_pos_t           pos_x_q, pos_y_q;

  logic               in_fire;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  logic [SAMPLE_BITS-1:0] rdata_a, rdata_b;
  logic               calc_done;
  ggl_result_t        calc_res;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q   <= (state_q == S_DRAIN);
      rd_pend_q <= mem_re;
      // result held until taken, reloaded from the final state
      if ((state_q == S_DONE) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && (in_i.operation == OP_QUERY)) begin
            cnt_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == LAST_TAP) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_CALC;
        end
        S_CALC: begin
          if (calc_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // query context and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      qx_q    <= qx_c;
      qy_q    <= qy_c;
      sx_q    <= sx_c;
      sy_q    <= sy_c;
      pos_x_q <= pos_x_c;
      pos_y_q <= pos_y_c;
    end
    if ((state_q == S_DONE) && (!out_valid_q || out_o.ready)) begin
      out_data_q <= calc_res;
    end
  end

  // store access: write on an in-grid write transaction, two taps per read cycle
  assign mem_we  = in_fire && (in_i.operation == OP_WRITE) && in_grid;
  assign waddr   = addr_of(in_i.x_coord, in_i.y_coord);
  assign mem_re  = (state_q == S_READ);
  assign raddr_a = addr_of(sx_q + COORD_W'(cnt_q), qy_q);
  assign raddr_b = addr_of(qx_q, sy_q + COORD_W'(cnt_q));

  ggl_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (waddr),
    .wdata_i   (SAMPLE_BITS'(in_i.sample_value)),
    .re_i      (mem_re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // window samples shift in as read data returns
  logic signed [SAMPLE_BITS-1:0] xs_q [3];
  logic signed [SAMPLE_BITS-1:0] ys_q [3];

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      xs_q[0] <= xs_q[1];
      xs_q[1] <= xs_q[2];
      xs_q[2] <= signed'(rdata_a);
      ys_q[0] <= ys_q[1];
      ys_q[1] <= ys_q[2];
      ys_q[2] <= signed'(rdata_b);
    end
  end

  ggl_calc #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .pos_x_i (pos_x_q),
    .pos_y_i (pos_y_q),
    .xs_i    (xs_q),
    .ys_i    (ys_q),
    .scale_i (scale_q),
    .done_o  (calc_done),
    .res_o   (calc_res)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.gradient_x      = out_data_q.gradient_x;
  assign out_o.gradient_y      = out_data_q.gradient_y;
  assign out_o.laplacian_value = out_data_q.laplacian_value;

  // a result is only published from the final state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result published outside of the final state");

  // datapath completes only while the sequencer waits for it
  a_calc_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_done |-> (state_q == S_CALC))
    else $error("datapath result arrived out of step");

  // the sequencer starts the datapath only after the last tap returned
  a_start_after_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> $past(rd_pend_q) && $past(state_q == S_DRAIN))
    else $error("datapath started before all taps captured");

endmodule
